[src/assert_macros.svh]
// Assertion macros shared by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that forces a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/pgc_pkg.sv]
// Shared types, constants and helper functions of the pointer gesture classifier.
package pgc_pkg;

    // Widths of time stamps and coordinates.
    localparam int TIME_BITS  = 32;
    localparam int COORD_BITS = 16;
    localparam int SLOP_BITS  = 8;
    localparam int THR_BITS   = 16;

    // Result bundles: up to three results per event.
    localparam int MAX_RES     = 3;
    localparam int CNT_BITS    = $clog2(MAX_RES + 1);
    localparam int QUEUE_DEPTH = 2;

    // Event codes.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_MOVE = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;
    localparam logic [1:0] ACT_UP   = 2'd3;

    // Gesture codes.
    localparam logic [2:0] G_MOVE    = 3'd0;
    localparam logic [2:0] G_PAUSE   = 3'd1;
    localparam logic [2:0] G_CLICK   = 3'd2;
    localparam logic [2:0] G_DOUBLE  = 3'd3;
    localparam logic [2:0] G_HOLD    = 3'd4;
    localparam logic [2:0] G_HCANCEL = 3'd5;
    localparam logic [2:0] G_HEND    = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_HOLD_MS   = 2'd0;
    localparam logic [1:0] REG_PAUSE_MS  = 2'd1;
    localparam logic [1:0] REG_DOUBLE_MS = 2'd2;
    localparam logic [1:0] REG_SLOP_PX   = 2'd3;

    // Reset values of the thresholds.
    localparam logic [THR_BITS-1:0]  HOLD_MS_RST   = 16'd500;
    localparam logic [THR_BITS-1:0]  PAUSE_MS_RST  = 16'd300;
    localparam logic [THR_BITS-1:0]  DOUBLE_MS_RST = 16'd400;
    localparam logic [SLOP_BITS-1:0] SLOP_PX_RST   = 8'd4;

    typedef struct packed {
        logic [THR_BITS-1:0]  hold_ms;
        logic [THR_BITS-1:0]  pause_ms;
        logic [THR_BITS-1:0]  double_ms;
        logic [SLOP_BITS-1:0] slop_px;
    } cfg_t;

    typedef struct packed {
        logic [2:0]                   kind;
        logic [7:0]                   surface;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [1:0]                   button;
    } res_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]     cnt;
        res_t [MAX_RES-1:0]      res;
    } bundle_t;

    // Builds one result record.
    function automatic res_t mk_res(logic [2:0] kind, logic [7:0] surface,
                                    logic signed [COORD_BITS-1:0] x,
                                    logic signed [COORD_BITS-1:0] y,
                                    logic [1:0] button);
        res_t r;
        r.kind    = kind;
        r.surface = surface;
        r.x       = x;
        r.y       = y;
        r.button  = button;
        return r;
    endfunction

    // True when button b (1..3) is set in the down mask; button 0 is never down.
    function automatic logic is_down(logic [2:0] mask, logic [1:0] b);
        logic res;
        res = 1'b0;
        if (b != 2'd0)
        begin
            res = mask[b - 2'd1];
        end
        return res;
    endfunction

endpackage

[src/pgc_front.sv]
// Front part: takes events, runs the deadline check and event rule, emits result bundles.
module pgc_front
    import pgc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [TIME_BITS-1:0]         time_ms,
    input  logic [3:0]                   button_number,
    input  logic                         has_position,
    input  logic [7:0]                   surface_id,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  cfg_t                         cfg,
    output logic                         push,
    output bundle_t                      push_bundle,
    input  logic                         q_full
);

    typedef enum logic [1:0] {PH_DIFF, PH_SQUARE, PH_DECIDE} phase_t;
    typedef enum logic [2:0] {M_IDLE, M_PRESSED, M_HOLDING, M_MOVING, M_AWAIT, M_POSTDBL}
        mode_t;

    // Control and gesture state.
    phase_t                       phase_reg;
    logic                         full_reg;
    mode_t                        mode_reg;
    logic [1:0]                   owner_reg;
    logic [2:0]                   mask_reg;
    logic [7:0]                   press_surf_reg;
    logic signed [COORD_BITS-1:0] press_x_reg;
    logic signed [COORD_BITS-1:0] press_y_reg;
    logic [TIME_BITS-1:0]         press_time_reg;
    logic [7:0]                   motion_surf_reg;
    logic signed [COORD_BITS-1:0] motion_x_reg;
    logic signed [COORD_BITS-1:0] motion_y_reg;
    logic [TIME_BITS-1:0]         motion_time_reg;

    // Held event.
    logic [1:0]                   act_reg;
    logic [TIME_BITS-1:0]         time_reg;
    logic [3:0]                   btn_reg;
    logic                         hp_reg;
    logic [7:0]                   surf_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;

    // Arithmetic pipeline registers.
    logic                         hold_hit_reg;
    logic                         pause_hit_reg;
    logic                         dbl_in_reg;
    logic                         over_reg;
    logic [SLOP_BITS-1:0]         adx_lo_reg;
    logic [SLOP_BITS-1:0]         ady_lo_reg;
    logic                         over_b_reg;
    logic [2*SLOP_BITS-1:0]       sqx_reg;
    logic [2*SLOP_BITS-1:0]       sqy_reg;
    logic [2*SLOP_BITS-1:0]       slsq_reg;

    logic                         in_acc;
    logic                         item_done;

    // Next values of the gesture state.
    mode_t                        mode_next;
    logic [1:0]                   owner_next;
    logic [2:0]                   mask_next;
    logic [7:0]                   press_surf_next;
    logic signed [COORD_BITS-1:0] press_x_next;
    logic signed [COORD_BITS-1:0] press_y_next;
    logic [TIME_BITS-1:0]         press_time_next;
    logic [7:0]                   motion_surf_next;
    logic signed [COORD_BITS-1:0] motion_x_next;
    logic signed [COORD_BITS-1:0] motion_y_next;
    logic [TIME_BITS-1:0]         motion_time_next;
    logic [CNT_BITS-1:0]          n_next;
    res_t [MAX_RES-1:0]           res_next;

    // Stage one signals: elapsed times and absolute distances.
    logic [TIME_BITS-1:0]         el_press;
    logic [TIME_BITS-1:0]         el_motion;
    logic [COORD_BITS:0]          dx;
    logic [COORD_BITS:0]          dy;
    logic [COORD_BITS-1:0]        adx;
    logic [COORD_BITS-1:0]        ady;
    logic [COORD_BITS-1:0]        slop_w;
    logic                         far;

    // Handshake: the held event finishes when the decision fits in the queue.
    assign item_done = full_reg && (phase_reg == PH_DECIDE) && !q_full;
    assign in_stall  = full_reg && !item_done;
    assign in_acc    = in_valid && !in_stall;

    // Stage one arithmetic.
    always_comb
    begin
        el_press  = time_reg - press_time_reg;
        el_motion = time_reg - motion_time_reg;
        dx        = {x_reg[COORD_BITS-1], x_reg} - {press_x_reg[COORD_BITS-1], press_x_reg};
        dy        = {y_reg[COORD_BITS-1], y_reg} - {press_y_reg[COORD_BITS-1], press_y_reg};
        adx       = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady       = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        slop_w    = COORD_BITS'(cfg.slop_px);
    end

    // Event hold register and arithmetic pipeline; event and state stay fixed per item.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg  <= action;
            time_reg <= time_ms;
            btn_reg  <= button_number;
            hp_reg   <= has_position;
            surf_reg <= surface_id;
            x_reg    <= pos_x;
            y_reg    <= pos_y;
        end
        hold_hit_reg  <= el_press >= TIME_BITS'(cfg.hold_ms);
        dbl_in_reg    <= el_press <= TIME_BITS'(cfg.double_ms);
        pause_hit_reg <= el_motion >= TIME_BITS'(cfg.pause_ms);
        over_reg      <= (surf_reg != press_surf_reg) || (adx > slop_w) || (ady > slop_w);
        adx_lo_reg    <= adx[SLOP_BITS-1:0];
        ady_lo_reg    <= ady[SLOP_BITS-1:0];
        over_b_reg    <= over_reg;
        sqx_reg       <= adx_lo_reg * adx_lo_reg;
        sqy_reg       <= ady_lo_reg * ady_lo_reg;
        slsq_reg      <= cfg.slop_px * cfg.slop_px;
    end

    // Slop test on the squared distance; a clipped axis or another surface is far.
    assign far = over_b_reg ||
                 (({1'b0, sqx_reg} + {1'b0, sqy_reg}) > {1'b0, slsq_reg});

    // Deadline check, then the event rule.
    always_comb
    begin
        logic [1:0] b;
        logic       b_ok;
        logic [2:0] bit_v;
        logic       owner_down;
        logic       was;

        mode_next        = mode_reg;
        owner_next       = owner_reg;
        mask_next        = mask_reg;
        press_surf_next  = press_surf_reg;
        press_x_next     = press_x_reg;
        press_y_next     = press_y_reg;
        press_time_next  = press_time_reg;
        motion_surf_next = motion_surf_reg;
        motion_x_next    = motion_x_reg;
        motion_y_next    = motion_y_reg;
        motion_time_next = motion_time_reg;
        n_next           = '0;
        res_next         = '0;

        b          = btn_reg[1:0];
        b_ok       = (btn_reg[3:2] == 2'd0) && (b != 2'd0);
        bit_v      = 3'(3'b001 << (b - 2'd1));
        owner_down = 1'b0;
        was        = 1'b0;

        // Deadline check.
        case (mode_reg)
            M_PRESSED:
            begin
                if (hold_hit_reg)
                begin
                    mode_next        = M_HOLDING;
                    res_next[n_next] = mk_res(G_HOLD, press_surf_reg, press_x_reg,
                                              press_y_reg, owner_reg);
                    n_next           = n_next + 1'b1;
                end
            end
            M_MOVING:
            begin
                if (pause_hit_reg)
                begin
                    mode_next        = M_IDLE;
                    res_next[n_next] = mk_res(G_PAUSE, motion_surf_reg, motion_x_reg,
                                              motion_y_reg, 2'd0);
                    n_next           = n_next + 1'b1;
                end
            end
            M_AWAIT:
            begin
                if (!dbl_in_reg)
                begin
                    mode_next        = M_IDLE;
                    res_next[n_next] = mk_res(G_CLICK, press_surf_reg, press_x_reg,
                                              press_y_reg, owner_reg);
                    n_next           = n_next + 1'b1;
                    if (!is_down(mask_reg, owner_reg))
                    begin
                        owner_next = 2'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Move with a position.
        if (act_reg == ACT_MOVE && hp_reg)
        begin
            case (mode_next)
                M_PRESSED:
                begin
                    if (far)
                    begin
                        mode_next        = M_MOVING;
                        motion_surf_next = surf_reg;
                        motion_x_next    = x_reg;
                        motion_y_next    = y_reg;
                        motion_time_next = time_reg;
                        res_next[n_next] = mk_res(G_MOVE, surf_reg, x_reg, y_reg, 2'd0);
                        n_next           = n_next + 1'b1;
                    end
                end
                M_HOLDING:
                begin
                    if (far)
                    begin
                        res_next[n_next] = mk_res(G_HCANCEL, surf_reg, x_reg, y_reg,
                                                  owner_next);
                        n_next           = n_next + 1'b1;
                        mode_next        = M_MOVING;
                        motion_surf_next = surf_reg;
                        motion_x_next    = x_reg;
                        motion_y_next    = y_reg;
                        motion_time_next = time_reg;
                        res_next[n_next] = mk_res(G_MOVE, surf_reg, x_reg, y_reg, 2'd0);
                        n_next           = n_next + 1'b1;
                    end
                end
                M_AWAIT:
                begin
                    if (far)
                    begin
                        res_next[n_next] = mk_res(G_CLICK, press_surf_reg, press_x_reg,
                                                  press_y_reg, owner_next);
                        n_next           = n_next + 1'b1;
                        owner_next       = 2'd0;
                        mode_next        = M_MOVING;
                        motion_surf_next = surf_reg;
                        motion_x_next    = x_reg;
                        motion_y_next    = y_reg;
                        motion_time_next = time_reg;
                        res_next[n_next] = mk_res(G_MOVE, surf_reg, x_reg, y_reg, 2'd0);
                        n_next           = n_next + 1'b1;
                    end
                end
                M_POSTDBL:
                begin
                    if (!is_down(mask_reg, owner_next))
                    begin
                        owner_next = 2'd0;
                    end
                    mode_next        = M_MOVING;
                    motion_surf_next = surf_reg;
                    motion_x_next    = x_reg;
                    motion_y_next    = y_reg;
                    motion_time_next = time_reg;
                    res_next[n_next] = mk_res(G_MOVE, surf_reg, x_reg, y_reg, 2'd0);
                    n_next           = n_next + 1'b1;
                end
                default:
                begin
                    mode_next        = M_MOVING;
                    motion_surf_next = surf_reg;
                    motion_x_next    = x_reg;
                    motion_y_next    = y_reg;
                    motion_time_next = time_reg;
                    res_next[n_next] = mk_res(G_MOVE, surf_reg, x_reg, y_reg, 2'd0);
                    n_next           = n_next + 1'b1;
                end
            endcase
        end
        // Button down; a repeated down changes nothing.
        else if (act_reg == ACT_DOWN && b_ok)
        begin
            owner_down = is_down(mask_reg, owner_next);
            if ((mask_reg & bit_v) == 3'b000)
            begin
                mask_next = mask_reg | bit_v;
                if (mode_next == M_AWAIT)
                begin
                    if (b == owner_next && hp_reg)
                    begin
                        if (dbl_in_reg && !far)
                        begin
                            mode_next        = M_POSTDBL;
                            res_next[n_next] = mk_res(G_DOUBLE, surf_reg, x_reg, y_reg, b);
                            n_next           = n_next + 1'b1;
                        end
                        else
                        begin
                            res_next[n_next] = mk_res(G_CLICK, press_surf_reg, press_x_reg,
                                                      press_y_reg, owner_next);
                            n_next           = n_next + 1'b1;
                            mode_next        = M_PRESSED;
                            press_surf_next  = surf_reg;
                            press_x_next     = x_reg;
                            press_y_next     = y_reg;
                            press_time_next  = time_reg;
                            owner_next       = b;
                        end
                    end
                end
                else if (mode_next != M_PRESSED && mode_next != M_HOLDING)
                begin
                    if (!owner_down)
                    begin
                        owner_next = b;
                        if (hp_reg)
                        begin
                            mode_next       = M_PRESSED;
                            press_surf_next = surf_reg;
                            press_x_next    = x_reg;
                            press_y_next    = y_reg;
                            press_time_next = time_reg;
                        end
                    end
                end
            end
        end
        // Button up; only the owner's release changes the mode.
        else if (act_reg == ACT_UP && b_ok)
        begin
            was       = (mask_reg & bit_v) != 3'b000;
            mask_next = mask_reg & ~bit_v;
            if (was && b == owner_next)
            begin
                if (mode_next == M_PRESSED)
                begin
                    if (hp_reg && far)
                    begin
                        mode_next  = M_IDLE;
                        owner_next = 2'd0;
                    end
                    else
                    begin
                        mode_next = M_AWAIT;
                    end
                end
                else if (mode_next == M_HOLDING)
                begin
                    mode_next = M_IDLE;
                    if (hp_reg)
                    begin
                        res_next[n_next] = mk_res(G_HEND, surf_reg, x_reg, y_reg, owner_next);
                    end
                    else
                    begin
                        res_next[n_next] = mk_res(G_HEND, press_surf_reg, press_x_reg,
                                                  press_y_reg, owner_next);
                    end
                    n_next     = n_next + 1'b1;
                    owner_next = 2'd0;
                end
                else if (mode_next != M_AWAIT && mode_next != M_POSTDBL)
                begin
                    owner_next = 2'd0;
                end
            end
        end
    end

    // Results of a finished event go to the queue when there are any.
    assign push            = item_done && (n_next != '0);
    assign push_bundle.cnt = n_next;
    assign push_bundle.res = res_next;

    // Sequencer and gesture state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_DIFF;
            full_reg        <= 1'b0;
            mode_reg        <= M_IDLE;
            owner_reg       <= 2'd0;
            mask_reg        <= 3'b000;
            press_surf_reg  <= '0;
            press_x_reg     <= '0;
            press_y_reg     <= '0;
            press_time_reg  <= '0;
            motion_surf_reg <= '0;
            motion_x_reg    <= '0;
            motion_y_reg    <= '0;
            motion_time_reg <= '0;
        end
        else
        begin
            case (phase_reg)
                PH_DIFF:
                begin
                    if (full_reg)
                    begin
                        phase_reg <= PH_SQUARE;
                    end
                    else if (in_acc)
                    begin
                        full_reg <= 1'b1;
                    end
                end
                PH_SQUARE:
                begin
                    phase_reg <= PH_DECIDE;
                end
                PH_DECIDE:
                begin
                    if (item_done)
                    begin
                        phase_reg       <= PH_DIFF;
                        full_reg        <= in_acc;
                        mode_reg        <= mode_next;
                        owner_reg       <= owner_next;
                        mask_reg        <= mask_next;
                        press_surf_reg  <= press_surf_next;
                        press_x_reg     <= press_x_next;
                        press_y_reg     <= press_y_next;
                        press_time_reg  <= press_time_next;
                        motion_surf_reg <= motion_surf_next;
                        motion_x_reg    <= motion_x_next;
                        motion_y_reg    <= motion_y_next;
                        motion_time_reg <= motion_time_next;
                    end
                end
                default:
                begin
                    phase_reg <= PH_DIFF;
                end
            endcase
        end
    end

endmodule

[src/pgc_queue.sv]
// Short queue of result bundles between the front and back parts.
module pgc_queue
    import pgc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    full,
    output logic    q_valid,
    output bundle_t q_bundle,
    input  logic    pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    bundle_t         entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = count_reg == CW'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign q_bundle = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/pgc_back.sv]
// Back part: drains one bundle at a time into single results through an output register.
module pgc_back
    import pgc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  bundle_t                      q_bundle,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   gesture_kind,
    output logic [7:0]                   at_surface,
    output logic signed [COORD_BITS-1:0] at_x,
    output logic signed [COORD_BITS-1:0] at_y,
    output logic [1:0]                   gesture_button,
    output logic                         last_of_run
);

    bundle_t             cur_reg;
    logic [CNT_BITS-1:0] idx_reg;
    logic                busy_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                send;
    logic                last_v;

    // One result leaves per cycle while the output register is free.
    assign out_free = !out_valid_reg || !out_stall;
    assign send     = busy_reg && out_free;
    assign last_v   = idx_reg == (cur_reg.cnt - CNT_BITS'(1));
    assign q_pop    = q_valid && (!busy_reg || (send && last_v));

    // Bundle being drained and output payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_bundle;
        end
        if (send)
        begin
            out_res_reg  <= cur_reg.res[idx_reg];
            out_last_reg <= last_v;
        end
    end

    // Drain control and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (send)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (send)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last_v)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign gesture_kind   = out_res_reg.kind;
    assign at_surface     = out_res_reg.surface;
    assign at_x           = out_res_reg.x;
    assign at_y           = out_res_reg.y;
    assign gesture_button = out_res_reg.button;
    assign last_of_run    = out_last_reg;

endmodule

[src/pointer_gesture_classifier_top.sv]
// Top level of the pointer gesture classifier: configuration registers and the three parts.
`include "assert_macros.svh"

// Turns timestamped pointer events into move, pause, click, double click, hold,
// hold cancel and hold end gestures. In the front part each event passes through
// elapsed times and distances, squares of the distances, then the decision and
// state update; the next event is taken at the clock edge where the current one
// leaves, so the input stalls while an event is in the front part, and longer
// while the decision waits for room in the queue. An event's results, up to three,
// go as one bundle through a two-entry queue to the back part, which hands them
// out one per cycle while out_stall is low, with last_of_run set on the final one.
// The user must write the thresholds through the cfg_we/cfg_index/cfg_data port
// only while no event is in flight; the block itself does not enforce it.
module pointer_gesture_classifier_top
    import pgc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [THR_BITS-1:0]          cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [TIME_BITS-1:0]         time_ms,
    input  logic [3:0]                   button_number,
    input  logic                         has_position,
    input  logic [7:0]                   surface_id,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   gesture_kind,
    output logic [7:0]                   at_surface,
    output logic signed [COORD_BITS-1:0] at_x,
    output logic signed [COORD_BITS-1:0] at_y,
    output logic [1:0]                   gesture_button,
    output logic                         last_of_run
);

    cfg_t    cfg_reg;
    logic    q_push;
    bundle_t q_push_bundle;
    logic    q_full;
    logic    q_valid;
    bundle_t q_bundle;
    logic    q_pop;

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ms   <= HOLD_MS_RST;
            cfg_reg.pause_ms  <= PAUSE_MS_RST;
            cfg_reg.double_ms <= DOUBLE_MS_RST;
            cfg_reg.slop_px   <= SLOP_PX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_MS:   cfg_reg.hold_ms   <= cfg_data;
                REG_PAUSE_MS:  cfg_reg.pause_ms  <= cfg_data;
                REG_DOUBLE_MS: cfg_reg.double_ms <= cfg_data;
                REG_SLOP_PX:   cfg_reg.slop_px   <= cfg_data[SLOP_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pgc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .time_ms       (time_ms),
        .button_number (button_number),
        .has_position  (has_position),
        .surface_id    (surface_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .cfg           (cfg_reg),
        .push          (q_push),
        .push_bundle   (q_push_bundle),
        .q_full        (q_full)
    );

    pgc_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_bundle (q_push_bundle),
        .full        (q_full),
        .q_valid     (q_valid),
        .q_bundle    (q_bundle),
        .pop         (q_pop)
    );

    pgc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_bundle       (q_bundle),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gesture_kind   (gesture_kind),
        .at_surface     (at_surface),
        .at_x           (at_x),
        .at_y           (at_y),
        .gesture_button (gesture_button),
        .last_of_run    (last_of_run)
    );

    // The front never pushes into a full queue and never pushes an empty bundle.
    `ASSERT_ALWAYS(a_no_overflow, !(q_push && q_full), "bundle pushed into a full queue")
    `ASSERT_ALWAYS(a_no_empty_bundle, !q_push || (q_push_bundle.cnt != '0), "empty bundle pushed")
    // A result that is not the last of its run is followed by another one.
    `ASSERT_NEXT(a_run_continues, out_valid && !last_of_run, out_valid, "result run broken off")

endmodule

[verif/pointer_gesture_classifier_top_tb.sv]
// Self-checking testbench for the pointer gesture classifier: directed and random events.
module pointer_gesture_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgc_pkg::*;

    // Receiver hold-off long enough to back the block up into its input.
    localparam int LONG_HOLD   = 120;
    localparam int SHOW_LIMIT  = 40;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PRESSED = 3'd1,
        MODE_HOLDING = 3'd2,
        MODE_MOVING  = 3'd3,
        MODE_AWAIT   = 3'd4,
        MODE_POSTDBL = 3'd5
    } gesture_mode_t;

    typedef struct packed {
        logic [1:0]                   action;
        logic [TIME_BITS-1:0]         time_ms;
        logic [3:0]                   button;
        logic                         has_pos;
        logic [7:0]                   surface;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } pointer_event_t;

    typedef struct packed {
        res_t res;
        logic last;
    } gesture_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port.
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = REG_HOLD_MS;
    logic [THR_BITS-1:0] cfg_data = '0;

    // Request side.
    logic           in_valid = 1'b0;
    logic           in_stall;
    pointer_event_t cur_ev = '0;

    // Result side.
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [2:0]                   gesture_kind;
    logic [7:0]                   at_surface;
    logic signed [COORD_BITS-1:0] at_x;
    logic signed [COORD_BITS-1:0] at_y;
    logic [1:0]                   gesture_button;
    logic                         last_of_run;

    // Pending requests and expected gestures.
    pointer_event_t event_q[$];
    gesture_rec_t   expected_gestures[$];
    gesture_rec_t   run_gestures[$];
    int events_queued = 0;
    int events_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;

    // Threshold copy, kept in step with every register write.
    logic [THR_BITS-1:0]  hold_thr  = HOLD_MS_RST;
    logic [THR_BITS-1:0]  pause_thr = PAUSE_MS_RST;
    logic [THR_BITS-1:0]  dbl_thr   = DOUBLE_MS_RST;
    logic [SLOP_BITS-1:0] slop_thr  = SLOP_PX_RST;

    // Gesture tracker state as seen by the predictor.
    gesture_mode_t                gesture_mode = MODE_IDLE;
    logic [1:0]                   owner_btn = 2'd0;
    logic [2:0]                   held_mask = 3'd0;
    logic [7:0]                   press_surf = 8'd0;
    logic signed [COORD_BITS-1:0] press_px = '0;
    logic signed [COORD_BITS-1:0] press_py = '0;
    logic [TIME_BITS-1:0]         press_t = '0;
    logic [7:0]                   motion_surf = 8'd0;
    logic signed [COORD_BITS-1:0] motion_px = '0;
    logic signed [COORD_BITS-1:0] motion_py = '0;
    logic [TIME_BITS-1:0]         motion_t = '0;

    // Stimulus generator state.
    logic [TIME_BITS-1:0] gen_now = '0;
    logic [7:0]           gen_surface = 8'd0;

    pointer_gesture_classifier_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (cur_ev.action),
        .time_ms        (cur_ev.time_ms),
        .button_number  (cur_ev.button),
        .has_position   (cur_ev.has_pos),
        .surface_id     (cur_ev.surface),
        .pos_x          (cur_ev.x),
        .pos_y          (cur_ev.y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gesture_kind   (gesture_kind),
        .at_surface     (at_surface),
        .at_x           (at_x),
        .at_y           (at_y),
        .gesture_button (gesture_button),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Prints one mismatch line (up to a limit) and counts it.
    task automatic flag_mismatch(string what);
        if (mismatches < SHOW_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // ---------------------------------------------------------------- predictor

    // True when the given button is currently held; button 0 never is.
    function automatic logic btn_held(logic [1:0] b);
        return (b != 2'd0) && held_mask[b - 2'd1];
    endfunction

    // A surface change or travel beyond the slop circle leaves the press point.
    function automatic logic beyond_slop(logic [7:0] s, logic signed [COORD_BITS-1:0] x,
                                         logic signed [COORD_BITS-1:0] y);
        longint dx;
        longint dy;
        longint sl;
        dx = longint'(x) - longint'(press_px);
        dy = longint'(y) - longint'(press_py);
        sl = longint'(slop_thr);
        if (s != press_surf)
        begin
            return 1'b1;
        end
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        if (dx > sl || dy > sl)
        begin
            return 1'b1;
        end
        return (dx * dx + dy * dy) > (sl * sl);
    endfunction

    function automatic void add_gesture(logic [2:0] kind, logic [7:0] s,
                                        logic signed [COORD_BITS-1:0] x,
                                        logic signed [COORD_BITS-1:0] y, logic [1:0] b);
        gesture_rec_t g;
        g.res.kind    = kind;
        g.res.surface = s;
        g.res.x       = x;
        g.res.y       = y;
        g.res.button  = b;
        g.last        = 1'b0;
        if (run_gestures.size() < MAX_RES)
        begin
            run_gestures = {run_gestures, g};
        end
    endfunction

    function automatic void begin_motion(pointer_event_t ev);
        gesture_mode = MODE_MOVING;
        motion_surf  = ev.surface;
        motion_px    = ev.x;
        motion_py    = ev.y;
        motion_t     = ev.time_ms;
    endfunction

    function automatic void open_press(pointer_event_t ev);
        gesture_mode = MODE_PRESSED;
        press_surf   = ev.surface;
        press_px     = ev.x;
        press_py     = ev.y;
        press_t      = ev.time_ms;
        owner_btn    = ev.button[1:0];
    endfunction

    // Works out the gestures one accepted request causes and queues them.
    function automatic void predict_gestures(pointer_event_t ev);
        logic [TIME_BITS-1:0] since;
        logic [2:0]           bit_sel;
        logic                 owner_was_down;
        logic                 prior_held;
        logic                 eligible;
        run_gestures.delete();
        eligible = (ev.button >= 4'd1) && (ev.button <= 4'd3);
        bit_sel  = 3'b001 << (ev.button[1:0] - 2'd1);

        // Deadlines run first, against the request's time.
        case (gesture_mode)
            MODE_PRESSED:
            begin
                since = ev.time_ms - press_t;
                if (since >= TIME_BITS'(hold_thr))
                begin
                    gesture_mode = MODE_HOLDING;
                    add_gesture(G_HOLD, press_surf, press_px, press_py, owner_btn);
                end
            end
            MODE_MOVING:
            begin
                since = ev.time_ms - motion_t;
                if (since >= TIME_BITS'(pause_thr))
                begin
                    gesture_mode = MODE_IDLE;
                    add_gesture(G_PAUSE, motion_surf, motion_px, motion_py, 2'd0);
                end
            end
            MODE_AWAIT:
            begin
                since = ev.time_ms - press_t;
                if (since > TIME_BITS'(dbl_thr))
                begin
                    gesture_mode = MODE_IDLE;
                    add_gesture(G_CLICK, press_surf, press_px, press_py, owner_btn);
                    if (!btn_held(owner_btn))
                    begin
                        owner_btn = 2'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Event rule.
        if (ev.action == ACT_MOVE && ev.has_pos)
        begin
            case (gesture_mode)
                MODE_PRESSED:
                begin
                    if (beyond_slop(ev.surface, ev.x, ev.y))
                    begin
                        begin_motion(ev);
                        add_gesture(G_MOVE, ev.surface, ev.x, ev.y, 2'd0);
                    end
                end
                MODE_HOLDING:
                begin
                    if (beyond_slop(ev.surface, ev.x, ev.y))
                    begin
                        add_gesture(G_HCANCEL, ev.surface, ev.x, ev.y, owner_btn);
                        begin_motion(ev);
                        add_gesture(G_MOVE, ev.surface, ev.x, ev.y, 2'd0);
                    end
                end
                MODE_AWAIT:
                begin
                    if (beyond_slop(ev.surface, ev.x, ev.y))
                    begin
                        add_gesture(G_CLICK, press_surf, press_px, press_py, owner_btn);
                        owner_btn = 2'd0;
                        begin_motion(ev);
                        add_gesture(G_MOVE, ev.surface, ev.x, ev.y, 2'd0);
                    end
                end
                MODE_POSTDBL:
                begin
                    if (!btn_held(owner_btn))
                    begin
                        owner_btn = 2'd0;
                    end
                    begin_motion(ev);
                    add_gesture(G_MOVE, ev.surface, ev.x, ev.y, 2'd0);
                end
                default:
                begin
                    begin_motion(ev);
                    add_gesture(G_MOVE, ev.surface, ev.x, ev.y, 2'd0);
                end
            endcase
        end
        else if (ev.action == ACT_DOWN && eligible)
        begin
            owner_was_down = btn_held(owner_btn);
            if ((held_mask & bit_sel) == 3'd0)
            begin
                held_mask = held_mask | bit_sel;
                if (gesture_mode == MODE_AWAIT)
                begin
                    // Only the owner with a position can turn the wait into a double click.
                    if (ev.button[1:0] == owner_btn && ev.has_pos)
                    begin
                        since = ev.time_ms - press_t;
                        if (since <= TIME_BITS'(dbl_thr)
                            && !beyond_slop(ev.surface, ev.x, ev.y))
                        begin
                            gesture_mode = MODE_POSTDBL;
                            add_gesture(G_DOUBLE, ev.surface, ev.x, ev.y, ev.button[1:0]);
                        end
                        else
                        begin
                            add_gesture(G_CLICK, press_surf, press_px, press_py, owner_btn);
                            open_press(ev);
                        end
                    end
                end
                else if (gesture_mode != MODE_PRESSED && gesture_mode != MODE_HOLDING)
                begin
                    if (!owner_was_down)
                    begin
                        owner_btn = ev.button[1:0];
                        if (ev.has_pos)
                        begin
                            open_press(ev);
                        end
                    end
                end
            end
        end
        else if (ev.action == ACT_UP && eligible)
        begin
            prior_held = (held_mask & bit_sel) != 3'd0;
            held_mask  = held_mask & ~bit_sel;
            if (prior_held && ev.button[1:0] == owner_btn)
            begin
                if (gesture_mode == MODE_PRESSED)
                begin
                    if (ev.has_pos && beyond_slop(ev.surface, ev.x, ev.y))
                    begin
                        gesture_mode = MODE_IDLE;
                        owner_btn    = 2'd0;
                    end
                    else
                    begin
                        gesture_mode = MODE_AWAIT;
                    end
                end
                else if (gesture_mode == MODE_HOLDING)
                begin
                    gesture_mode = MODE_IDLE;
                    if (ev.has_pos)
                    begin
                        add_gesture(G_HEND, ev.surface, ev.x, ev.y, owner_btn);
                    end
                    else
                    begin
                        add_gesture(G_HEND, press_surf, press_px, press_py, owner_btn);
                    end
                    owner_btn = 2'd0;
                end
                else if (gesture_mode != MODE_AWAIT && gesture_mode != MODE_POSTDBL)
                begin
                    owner_btn = 2'd0;
                end
            end
        end

        // The final gesture of the run carries the last flag.
        if (run_gestures.size() != 0)
        begin
            run_gestures[run_gestures.size() - 1].last = 1'b1;
        end
        foreach (run_gestures[i])
        begin
            expected_gestures = {expected_gestures, run_gestures[i]};
        end
    endfunction

    // ------------------------------------------------------------ request driver

    // Offers queued requests, predicting each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        int unsigned rest;
        int unsigned sender_wait;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sender_wait = 0;
        end
        else if (in_valid && !in_stall)
        begin
            predict_gestures(cur_ev);
            events_accepted++;
            rest = ((events_accepted / 16) % 3 == 0) ? 0 : $urandom_range(0, 8);
            if (rest == 0 && event_q.size() != 0)
            begin
                cur_ev <= event_q.pop_front();
            end
            else
            begin
                in_valid    <= 1'b0;
                sender_wait = (rest == 0) ? 0 : rest - 1;
            end
        end
        else if (!in_valid)
        begin
            if (sender_wait != 0)
            begin
                sender_wait = sender_wait - 1;
            end
            else if (event_q.size() != 0)
            begin
                cur_ev   <= event_q.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // ----------------------------------------------------------- result monitor

    // Takes gestures with random hold-offs and checks each against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : watch_gestures
        int unsigned  hold_left;
        gesture_rec_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_gestures.size() == 0)
                begin
                    flag_mismatch($sformatf("gesture kind %0d at (%0d,%0d) with none expected",
                                            gesture_kind, at_x, at_y));
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (gesture_kind !== want.res.kind)
                    begin
                        flag_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                                results_seen, gesture_kind, want.res.kind));
                    end
                    if (at_surface !== want.res.surface)
                    begin
                        flag_mismatch($sformatf("result %0d: surface %0d, expected %0d",
                                                results_seen, at_surface, want.res.surface));
                    end
                    if (at_x !== want.res.x)
                    begin
                        flag_mismatch($sformatf("result %0d: x %0d, expected %0d",
                                                results_seen, at_x, want.res.x));
                    end
                    if (at_y !== want.res.y)
                    begin
                        flag_mismatch($sformatf("result %0d: y %0d, expected %0d",
                                                results_seen, at_y, want.res.y));
                    end
                    if (gesture_button !== want.res.button)
                    begin
                        flag_mismatch($sformatf("result %0d: button %0d, expected %0d",
                                                results_seen, gesture_button, want.res.button));
                    end
                    if (last_of_run !== want.last)
                    begin
                        flag_mismatch($sformatf("result %0d: last flag %0b, expected %0b",
                                                results_seen, last_of_run, want.last));
                    end
                end
                // Quiet stretches, random hold-offs and two long back-ups.
                hold_left = ((results_seen / 12) % 3 == 0) ? 0 : $urandom_range(0, 8);
                if (results_seen == 40 || results_seen == 140)
                begin
                    hold_left = LONG_HOLD;
                end
            end
            else if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
            end
            out_stall <= (hold_left != 0);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_event(logic [1:0] act, logic [TIME_BITS-1:0] t, logic [3:0] b,
                               logic hp, logic [7:0] s, logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y);
        pointer_event_t ev;
        ev.action  = act;
        ev.time_ms = t;
        ev.button  = b;
        ev.has_pos = hp;
        ev.surface = s;
        ev.x       = x;
        ev.y       = y;
        event_q = {event_q, ev};
        events_queued++;
    endtask

    task automatic queue_after(logic [TIME_BITS-1:0] delay, logic [1:0] act, logic [3:0] b,
                               logic hp, logic [7:0] s, logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y);
        gen_now = gen_now + delay;
        queue_event(act, gen_now, b, hp, s, x, y);
    endtask

    // Delay that mostly stays short or lands right at a threshold, rarely jumps far.
    function automatic logic [TIME_BITS-1:0] pick_delay(logic [THR_BITS-1:0] thr);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 7)
        begin
            return $urandom_range(0, 40);
        end
        else if (r < 11)
        begin
            return TIME_BITS'(thr) + $urandom_range(0, 2) - 1;
        end
        else if (r < 15)
        begin
            return $urandom_range(0, 2 * int'(thr) + 10);
        end
        return $urandom;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] nudge(logic signed [COORD_BITS-1:0] c,
                                                           int spread);
        int off;
        off = int'($urandom_range(0, 2 * spread)) - spread;
        return c + COORD_BITS'(off);
    endfunction

    function automatic logic usually();
        return $urandom_range(0, 5) != 0;
    endfunction

    // Mostly well-formed click, double click, hold, drag and wander sequences, plus noise.
    task automatic random_gestures(int count);
        int                           first;
        int                           near;
        int                           far;
        logic [3:0]                   btn;
        logic [7:0]                   surf;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        first = events_queued;
        while (events_queued - first < count)
        begin
            near = int'(slop_thr) + 1;
            far  = int'(slop_thr) + 60;
            btn  = 4'($urandom_range(1, 3));
            px   = COORD_BITS'($urandom);
            py   = COORD_BITS'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                gen_surface = 8'($urandom);
            end
            surf = gen_surface;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Single click, then let the window run out.
                    queue_after(pick_delay(pause_thr), ACT_DOWN, btn, usually(), surf, px, py);
                    queue_after(pick_delay(hold_thr), ACT_UP, btn, usually(), surf,
                                nudge(px, near), nudge(py, near));
                    queue_after(pick_delay(dbl_thr), ACT_TICK, 4'd0, 1'b0, surf, px, py);
                end
                2, 3:
                begin
                    // Double click attempt.
                    queue_after(pick_delay(pause_thr), ACT_DOWN, btn, usually(), surf, px, py);
                    queue_after(pick_delay(hold_thr), ACT_UP, btn, usually(), surf,
                                nudge(px, near), nudge(py, near));
                    queue_after(pick_delay(dbl_thr), ACT_DOWN, btn, usually(), surf,
                                nudge(px, near), nudge(py, near));
                    queue_after(pick_delay(hold_thr), ACT_UP, btn, usually(), surf, px, py);
                end
                4:
                begin
                    // Hold, maybe wobbled or cancelled by travel, then released.
                    queue_after(pick_delay(pause_thr), ACT_DOWN, btn, usually(), surf, px, py);
                    queue_after(pick_delay(hold_thr), ACT_TICK, 4'd0, 1'b0, surf, px, py);
                    queue_after(pick_delay(hold_thr), ACT_MOVE, 4'd0, usually(),
                                ($urandom_range(0, 3) == 0) ? 8'($urandom) : surf,
                                nudge(px, $urandom_range(0, 1) ? near : far),
                                nudge(py, near));
                    queue_after(pick_delay(hold_thr), ACT_UP, btn, usually(), surf,
                                nudge(px, near), nudge(py, near));
                end
                5:
                begin
                    // Drag: press, travel, release.
                    queue_after(pick_delay(pause_thr), ACT_DOWN, btn, usually(), surf, px, py);
                    repeat ($urandom_range(1, 3))
                    begin
                        px = nudge(px, far);
                        py = nudge(py, far);
                        queue_after(pick_delay(pause_thr), ACT_MOVE, 4'd0, usually(),
                                    surf, px, py);
                    end
                    queue_after(pick_delay(hold_thr), ACT_UP, btn, usually(), surf, px, py);
                end
                6, 7:
                begin
                    // Pointer wanders, then rests.
                    repeat ($urandom_range(1, 3))
                    begin
                        px = nudge(px, far);
                        py = nudge(py, far);
                        queue_after(pick_delay(pause_thr), ACT_MOVE, 4'd0, usually(),
                                    surf, px, py);
                    end
                    queue_after(pick_delay(pause_thr), ACT_TICK, 4'd0, 1'b0, surf, px, py);
                end
                default:
                begin
                    // Noise over the whole range of every field.
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_after($urandom_range(0, 1) ? $urandom : $urandom_range(0, 600),
                                    2'($urandom), 4'($urandom), 1'($urandom), 8'($urandom),
                                    COORD_BITS'($urandom), COORD_BITS'($urandom));
                    end
                end
            endcase
        end
    endtask

    // Waits until every request is taken and every gesture is back, then a bit more.
    task automatic wait_quiet(int extra);
        while (events_accepted != events_queued || expected_gestures.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [THR_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HOLD_MS:   hold_thr  = data;
            REG_PAUSE_MS:  pause_thr = data;
            REG_DOUBLE_MS: dbl_thr   = data;
            REG_SLOP_PX:   slop_thr  = data[SLOP_BITS-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic write_thresholds(logic [THR_BITS-1:0] hold_v, logic [THR_BITS-1:0] pause_v,
                                    logic [THR_BITS-1:0] dbl_v, logic [THR_BITS-1:0] slop_v);
        write_reg(REG_HOLD_MS, hold_v);
        write_reg(REG_PAUSE_MS, pause_v);
        write_reg(REG_DOUBLE_MS, dbl_v);
        write_reg(REG_SLOP_PX, slop_v);
    endtask

    // ------------------------------------------------------------------ sequence

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        gen_surface = 8'($urandom);

        // Directed walk through the state machine at the reset thresholds.
        queue_event(ACT_MOVE, 32'd10, 4'd0, 1'b1, 8'd1, 16'sd32767, 16'sh8000);
        queue_event(ACT_TICK, 32'd400, 4'd0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_event(ACT_DOWN, 32'd1000, 4'd1, 1'b1, 8'd1, 16'sd100, 16'sd100);
        queue_event(ACT_MOVE, 32'd1020, 4'd0, 1'b0, 8'd9, 16'sd900, 16'sd900);
        queue_event(ACT_UP, 32'd1100, 4'd1, 1'b1, 8'd1, 16'sd103, 16'sd100);
        // Second press after the double-click window has run out.
        queue_event(ACT_DOWN, 32'd1500, 4'd1, 1'b1, 8'd1, 16'sd102, 16'sd102);
        queue_event(ACT_UP, 32'd1550, 4'd1, 1'b1, 8'd1, 16'sd102, 16'sd102);
        queue_event(ACT_MOVE, 32'd1560, 4'd0, 1'b1, 8'd1, 16'sd0, 16'sd0);
        queue_event(ACT_DOWN, 32'd1600, 4'd2, 1'b1, 8'd2, -16'sd5, -16'sd5);
        queue_event(ACT_DOWN, 32'd1610, 4'd2, 1'b1, 8'd2, -16'sd5, -16'sd5);
        queue_event(ACT_TICK, 32'd2100, 4'd0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        // Surface change during a hold cancels it.
        queue_event(ACT_MOVE, 32'd2110, 4'd0, 1'b1, 8'd3, -16'sd5, -16'sd5);
        queue_event(ACT_UP, 32'd2120, 4'd2, 1'b1, 8'd3, -16'sd5, -16'sd5);
        queue_event(ACT_UP, 32'd2130, 4'd2, 1'b1, 8'd3, -16'sd5, -16'sd5);
        queue_event(ACT_DOWN, 32'd2140, 4'd0, 1'b1, 8'd3, 16'sd1, 16'sd1);
        queue_event(ACT_DOWN, 32'd2150, 4'd15, 1'b1, 8'd3, 16'sd1, 16'sd1);
        // Down without a position takes ownership but starts no press.
        queue_event(ACT_DOWN, 32'd2500, 4'd3, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_event(ACT_DOWN, 32'd2510, 4'd1, 1'b1, 8'd0, 16'sd7, 16'sd7);
        queue_event(ACT_UP, 32'd2520, 4'd1, 1'b1, 8'd0, 16'sd7, 16'sd7);
        queue_event(ACT_UP, 32'd2530, 4'd3, 1'b1, 8'd0, 16'sd7, 16'sd7);
        // Hold across the time wrap, released without a position.
        queue_event(ACT_DOWN, 32'hFFFF_FF00, 4'd3, 1'b1, 8'd255, 16'sd0, 16'sd0);
        queue_event(ACT_TICK, 32'h0000_0100, 4'd0, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_event(ACT_UP, 32'h0000_0110, 4'd3, 1'b0, 8'd0, 16'sd0, 16'sd0);
        // Waiting for a second press: a down without position is ignored, travel clicks.
        queue_event(ACT_DOWN, 32'h0000_1000, 4'd1, 1'b1, 8'd0, 16'sd10, 16'sd10);
        queue_event(ACT_UP, 32'h0000_1010, 4'd1, 1'b0, 8'd0, 16'sd0, 16'sd0);
        queue_event(ACT_DOWN, 32'h0000_1020, 4'd1, 1'b0, 8'd0, 16'sd10, 16'sd10);
        queue_event(ACT_UP, 32'h0000_1030, 4'd1, 1'b1, 8'd0, 16'sd10, 16'sd10);
        queue_event(ACT_MOVE, 32'h0000_1040, 4'd0, 1'b1, 8'd0, 16'sd20, 16'sd10);
        gen_now = 32'h0000_2000;
        random_gestures(30);
        wait_quiet(12);

        // Every threshold at zero; the slop write carries junk in its upper byte.
        write_thresholds(16'd0, 16'd0, 16'd0, {8'($urandom), 8'd0});
        random_gestures(25);
        wait_quiet(12);

        // Every threshold at its largest value.
        write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, {8'($urandom), 8'hFF});
        random_gestures(25);
        wait_quiet(12);

        // Ordinary random settings.
        write_thresholds(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1000)),
                         16'($urandom_range(0, 800)), 16'($urandom_range(0, 12)));
        random_gestures(30);
        wait_quiet(12);

        write_thresholds(16'($urandom), 16'($urandom_range(0, 600)),
                         16'($urandom_range(0, 600)), 16'($urandom));
        random_gestures(30);
        wait_quiet(20);

        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit well above the slowest correct run.
    initial
    begin
        #400_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/pgc_pkg.sv
src/pgc_front.sv
src/pgc_queue.sv
src/pgc_back.sv
src/pointer_gesture_classifier_top.sv
verif/pointer_gesture_classifier_top_tb.sv
